[hw/rtl/rsi_pkg.sv]
// shared constants and register codes for the ray/sphere intersection unit
package rsi_pkg;

  // default field widths
  localparam int COORD_WIDTH_DEF = 32;
  localparam int UNIT_WIDTH_DEF  = 16;

  // near threshold register width
  localparam int NEAR_WIDTH = 16;

  // configuration index width
  localparam int CFG_INDEX_W = 3;

  // register reset values
  localparam logic [63:0]           RADIUS_RESET = 64'd65536;
  localparam logic [NEAR_WIDTH-1:0] NEAR_RESET   = 16'd66;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CENTER_X       = 3'd0,
    CFG_CENTER_Y       = 3'd1,
    CFG_CENTER_Z       = 3'd2,
    CFG_SPHERE_RADIUS  = 3'd3,
    CFG_NEAR_THRESHOLD = 3'd4
  } cfg_reg_t;

endpackage

[hw/rtl/rsi_delay.sv]
// fixed-length register delay line for side data
module rsi_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [0:N-1];

  // shift one place per cycle
  always_ff @(posedge clk) begin
    pipe[0] <= d;
    for (int i = 1; i < N; i++) begin
      pipe[i] <= pipe[i-1];
    end
  end

  assign q = pipe[N-1];

endmodule

[hw/rtl/rsi_mul.sv]
// two-stage signed multiplier built from four half-width partial products
module rsi_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                  clk,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int BL = BW / 2;
  localparam int PW = AW + BW;

  logic signed [AW-AL-1:0] a_hi;
  logic        [AL-1:0]    a_lo;
  logic signed [BW-BL-1:0] b_hi;
  logic        [BL-1:0]    b_lo;

  logic signed [AW-AL+BW-BL-1:0] pp_hh;
  logic signed [AW-AL+BL:0]      pp_hl;
  logic signed [AL+BW-BL:0]      pp_lh;
  logic        [AL+BL-1:0]       pp_ll;

  assign a_hi = a[AW-1:AL];
  assign a_lo = a[AL-1:0];
  assign b_hi = b[BW-1:BL];
  assign b_lo = b[BL-1:0];

  // stage 1: partial products
  always_ff @(posedge clk) begin
    pp_hh <= a_hi * b_hi;
    pp_hl <= a_hi * $signed({1'b0, b_lo});
    pp_lh <= $signed({1'b0, a_lo}) * b_hi;
    pp_ll <= a_lo * b_lo;
  end

  // stage 2: aligned sum
  always_ff @(posedge clk) begin
    p <= (PW'(pp_hh) <<< (AL + BL)) + (PW'(pp_hl) <<< AL) + (PW'(pp_lh) <<< BL)
         + $signed(PW'(pp_ll));
  end

endmodule

[hw/rtl/rsi_sqrt.sv]
// pipelined integer square root, one root bit per stage
module rsi_sqrt #(
  parameter int RW = 16
) (
  input  logic            clk,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  logic [2*RW-1:0] rad_s  [0:RW];
  logic [RW+1:0]   rem_s  [0:RW];
  logic [RW-1:0]   root_s [0:RW];

  // input register
  always_ff @(posedge clk) begin
    rad_s[0]  <= rad;
    rem_s[0]  <= '0;
    root_s[0] <= '0;
  end

  // one digit per stage: bring down two bits, try root*4+1
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] sh;
    logic [RW+1:0] trial;

    always_comb begin
      sh    = {rem_s[k][RW-1:0], rad_s[k][2*RW-1 -: 2]};
      trial = {root_s[k], 2'b01};
    end

    always_ff @(posedge clk) begin
      rad_s[k+1] <= rad_s[k] << 2;
      if (sh >= trial) begin
        rem_s[k+1]  <= sh - trial;
        root_s[k+1] <= {root_s[k][RW-2:0], 1'b1};
      end else begin
        rem_s[k+1]  <= sh;
        root_s[k+1] <= {root_s[k][RW-2:0], 1'b0};
      end
    end
  end

  assign root = root_s[RW];

endmodule

[hw/rtl/rsi_div.sv]
// pipelined restoring divider for one normal component, rounded and clamped
module rsi_div #(
  parameter int NW = 16,
  parameter int DW = 16,
  parameter int QB = 15
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  localparam int FW = QB - 1;
  localparam int RW = (((NW + FW + 1) > (DW + QB)) ? (NW + FW + 1) : (DW + QB)) + 1;
  localparam logic [QB-1:0] LIM = QB'(1) << FW;

  logic [RW-1:0] rem_s [0:QB];
  logic [DW-1:0] den_s [0:QB];
  logic [QB-1:0] q_s   [0:QB];
  logic          ovf_s [0:QB];

  logic [RW-1:0] rem_in;

  // scaled numerator plus half the divisor for round half up
  assign rem_in = (RW'(num) << FW) + RW'(den >> 1);

  // stage 0: overflow check against the full quotient range
  always_ff @(posedge clk) begin
    rem_s[0] <= rem_in;
    den_s[0] <= den;
    q_s[0]   <= '0;
    ovf_s[0] <= rem_in >= (RW'(den) << QB);
  end

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] dsh;

    assign dsh = RW'(den_s[k]) << (QB - 1 - k);

    always_ff @(posedge clk) begin
      den_s[k+1] <= den_s[k];
      ovf_s[k+1] <= ovf_s[k];
      if (rem_s[k] >= dsh) begin
        rem_s[k+1] <= rem_s[k] - dsh;
        q_s[k+1]   <= q_s[k] | (QB'(1) << (QB - 1 - k));
      end else begin
        rem_s[k+1] <= rem_s[k];
        q_s[k+1]   <= q_s[k];
      end
    end
  end

  // clamp to unit length
  assign quo = (ovf_s[QB] || (q_s[QB] > LIM)) ? LIM : q_s[QB];

endmodule

[hw/rtl/ray_sphere_intersect_unit.sv]
// top level: pipelined ray/sphere intersection with configuration registers
//
// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------------------
// ray in    | start / busy           | origin_x/y/z, dir_x/y/z
// result    | done (one-cycle pulse) | hit, hit_distance, hit_x/y/z, normal_x/y/z
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item enters per cycle while busy is low; each result's delay after its start grows with
// the two square-root pipelines (one stage per root bit) and the normal divider (one stage per
// quotient bit).
// busy follows reset only; the pipeline never stalls since results cannot be held off.
// reset clears valid bits and loads configuration defaults; cfg_ready is always high.
module ray_sphere_intersect_unit #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
  parameter int UNIT_WIDTH  = rsi_pkg::UNIT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // ray in
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      origin_x,
  input  logic signed [COORD_WIDTH-1:0]      origin_y,
  input  logic signed [COORD_WIDTH-1:0]      origin_z,
  input  logic signed [UNIT_WIDTH-1:0]       dir_x,
  input  logic signed [UNIT_WIDTH-1:0]       dir_y,
  input  logic signed [UNIT_WIDTH-1:0]       dir_z,
  // result
  output logic                               done,
  output logic                               hit,
  output logic [COORD_WIDTH-2:0]             hit_distance,
  output logic signed [COORD_WIDTH-1:0]      hit_x,
  output logic signed [COORD_WIDTH-1:0]      hit_y,
  output logic signed [COORD_WIDTH-1:0]      hit_z,
  output logic signed [UNIT_WIDTH-1:0]       normal_x,
  output logic signed [UNIT_WIDTH-1:0]       normal_y,
  output logic signed [UNIT_WIDTH-1:0]       normal_z,
  // config
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsi_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]             cfg_data
);

  localparam int CW     = COORD_WIDTH;
  localparam int UW     = UNIT_WIDTH;
  localparam int UF     = UW - 2;
  localparam int NEAR_W = rsi_pkg::NEAR_WIDTH;
  localparam int RAD_W  = CW - 1;
  localparam int REL_W  = CW + 1;
  localparam int PD_W   = REL_W + UW;
  localparam int BQ_W   = PD_W + 2;
  localparam int B_W    = BQ_W - UF;
  localparam int DISC_W = 2 * B_W + 1;
  localparam int S_W    = B_W;
  localparam int T_W    = B_W + 2;
  localparam int TD_W   = T_W + UW;
  localparam int P_W    = T_W + 3;
  localparam int V_W    = P_W + 1;
  localparam int LSQ_W  = 2 * V_W;
  localparam int LEN_W  = V_W;
  localparam int Q_W    = UF + 1;

  // stage numbers along the pipe
  localparam int MUL_LAT = 2;
  localparam int SQB_LAT = S_W + 1;
  localparam int SQL_LAT = LEN_W + 1;
  localparam int DIV_LAT = Q_W + 1;
  localparam int ST_A    = 6 + SQB_LAT;
  localparam int ST_B    = ST_A + 6 + MUL_LAT + SQL_LAT;
  localparam int ST_C    = ST_B + DIV_LAT;
  localparam int LAT     = ST_C + 1;

  localparam logic signed [T_W-1:0] DMAX = T_W'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [P_W-1:0] CMAX = P_W'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [P_W-1:0] CMIN = ~CMAX;
  localparam logic signed [UW-1:0]  NLIM = UW'(1) << UF;

  // configuration registers
  logic signed [CW-1:0]     center_x, center_y, center_z;
  logic        [RAD_W-1:0]  sphere_radius;
  logic        [NEAR_W-1:0] near_threshold;

  logic signed [CW-1:0] cen [3];
  logic signed [CW-1:0] org [3];
  logic signed [UW-1:0] dir [3];

  logic [LAT-1:1] vld;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;
  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      center_z       <= '0;
      sphere_radius  <= RAD_W'(rsi_pkg::RADIUS_RESET);
      near_threshold <= rsi_pkg::NEAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rsi_pkg::cfg_reg_t'(cfg_index))
        rsi_pkg::CFG_CENTER_X:       center_x       <= cfg_data;
        rsi_pkg::CFG_CENTER_Y:       center_y       <= cfg_data;
        rsi_pkg::CFG_CENTER_Z:       center_z       <= cfg_data;
        rsi_pkg::CFG_SPHERE_RADIUS:  sphere_radius  <= cfg_data[RAD_W-1:0];
        rsi_pkg::CFG_NEAR_THRESHOLD: near_threshold <= cfg_data[NEAR_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:1], start && !busy};
    end
  end

  // stage 1: relative center
  logic signed [REL_W-1:0] rel1 [3];
  logic signed [CW-1:0]    o1   [3];
  logic signed [UW-1:0]    d1   [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rel1[i] <= REL_W'(cen[i]) - REL_W'(org[i]);
      o1[i]   <= org[i];
      d1[i]   <= dir[i];
    end
  end

  // stage 2: direction products; squared distances run in parallel
  logic signed [PD_W-1:0]    pd2    [3];
  logic signed [2*REL_W-1:0] rel_sq [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pd2[i] <= d1[i] * rel1[i];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_relsq
    rsi_mul #(.AW(REL_W), .BW(REL_W)) u_mul (
      .clk (clk),
      .a   (rel1[i]),
      .b   (rel1[i]),
      .p   (rel_sq[i])
    );
  end

  // radius squared, refreshed every cycle
  logic signed [2*CW-1:0] rr;

  rsi_mul #(.AW(CW), .BW(CW)) u_rr (
    .clk (clk),
    .a   ($signed({1'b0, sphere_radius})),
    .b   ($signed({1'b0, sphere_radius})),
    .p   (rr)
  );

  // stage 3: half-b term
  logic signed [BQ_W-1:0] bq;
  logic signed [B_W-1:0]  b3;

  always_comb begin
    bq = BQ_W'(pd2[0]) + BQ_W'(pd2[1]) + BQ_W'(pd2[2]);
  end

  always_ff @(posedge clk) begin
    b3 <= B_W'(bq >>> UF);
  end

  // stage 4 and 5: negated c term, b squared
  logic signed [DISC_W-1:0] csum4, csum5;
  logic signed [2*B_W-1:0]  b2;

  always_ff @(posedge clk) begin
    csum4 <= DISC_W'(rr) - DISC_W'(rel_sq[0]) - DISC_W'(rel_sq[1]) - DISC_W'(rel_sq[2]);
    csum5 <= csum4;
  end

  rsi_mul #(.AW(B_W), .BW(B_W)) u_bsq (
    .clk (clk),
    .a   (b3),
    .b   (b3),
    .p   (b2)
  );

  // stage 6: reduced discriminant
  logic signed [DISC_W-1:0] disc6;

  always_ff @(posedge clk) begin
    disc6 <= DISC_W'(b2) + csum5;
  end

  // root of the discriminant
  logic [S_W-1:0] s_a;
  logic           neg_a;
  logic [B_W-1:0] b_a_raw;

  rsi_sqrt #(.RW(S_W)) u_sqrt_disc (
    .clk  (clk),
    .rad  (disc6[2*S_W-1:0]),
    .root (s_a)
  );

  rsi_delay #(.W(1), .N(SQB_LAT)) u_dly_neg (
    .clk (clk),
    .d   (disc6[DISC_W-1]),
    .q   (neg_a)
  );

  rsi_delay #(.W(B_W), .N(ST_A - 3)) u_dly_b (
    .clk (clk),
    .d   (b3),
    .q   (b_a_raw)
  );

  // stage A+1: both roots
  logic signed [T_W-1:0] t1, t2;
  logic                  neg_a1;

  always_ff @(posedge clk) begin
    t1     <= T_W'($signed(b_a_raw)) - T_W'($signed({1'b0, s_a}));
    t2     <= T_W'($signed(b_a_raw)) + T_W'($signed({1'b0, s_a}));
    neg_a1 <= neg_a;
  end

  // stage A+2: root selection against the near threshold
  logic signed [T_W-1:0] near;
  logic signed [T_W-1:0] t_a2;
  logic                  miss_a2;

  assign near = T_W'($signed({1'b0, near_threshold}));

  always_ff @(posedge clk) begin
    miss_a2 <= neg_a1 || ((t1 < near) && (t2 < near));
    t_a2    <= (t1 > near) ? t1 : t2;
  end

  // direction and origin catch up with the distance
  logic signed [UW-1:0] d_a2 [3];
  logic signed [CW-1:0] o_a3 [3];

  for (genvar i = 0; i < 3; i++) begin : g_dly_ray
    rsi_delay #(.W(UW), .N(ST_A + 1)) u_dly_d (
      .clk (clk),
      .d   (d1[i]),
      .q   (d_a2[i])
    );
    rsi_delay #(.W(CW), .N(ST_A + 2)) u_dly_o (
      .clk (clk),
      .d   (o1[i]),
      .q   (o_a3[i])
    );
  end

  // stage A+3: scaled offsets along the ray, saturated distance
  logic signed [TD_W-1:0]  td     [3];
  logic signed [T_W+1:0]   pdt_a3 [3];
  logic        [RAD_W-1:0] dist_a3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      td[i] = TD_W'(t_a2) * TD_W'(d_a2[i]);
    end
  end

  always_ff @(posedge clk) begin
    dist_a3 <= (t_a2 > DMAX) ? {RAD_W{1'b1}} : t_a2[RAD_W-1:0];
    for (int i = 0; i < 3; i++) begin
      pdt_a3[i] <= td[i][TD_W-1:UF];
    end
  end

  // stage A+4: hit point
  logic signed [P_W-1:0] p_a4 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_a4[i] <= P_W'(o_a3[i]) + P_W'(pdt_a3[i]);
    end
  end

  // stage A+5: vector from center, saturated hit point
  logic signed [V_W-1:0] v_a5    [3];
  logic signed [CW-1:0]  hsat_a5 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      v_a5[i] <= V_W'(p_a4[i]) - V_W'(cen[i]);
      if (p_a4[i] > CMAX) begin
        hsat_a5[i] <= CMAX[CW-1:0];
      end else if (p_a4[i] < CMIN) begin
        hsat_a5[i] <= CMIN[CW-1:0];
      end else begin
        hsat_a5[i] <= p_a4[i][CW-1:0];
      end
    end
  end

  // stage A+6: magnitudes and signs; squares run in parallel
  logic [V_W-1:0]          vm_a6 [3];
  logic                    vs_a6 [3];
  logic signed [2*V_W-1:0] vsq   [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      vm_a6[i] <= v_a5[i][V_W-1] ? V_W'(-v_a5[i]) : V_W'(v_a5[i]);
      vs_a6[i] <= v_a5[i][V_W-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_vsq
    rsi_mul #(.AW(V_W), .BW(V_W)) u_mul (
      .clk (clk),
      .a   (v_a5[i]),
      .b   (v_a5[i]),
      .p   (vsq[i])
    );
  end

  // stage A+8: squared length
  logic [LSQ_W-1:0] lsq;

  always_ff @(posedge clk) begin
    lsq <= LSQ_W'(vsq[0]) + LSQ_W'(vsq[1]) + LSQ_W'(vsq[2]);
  end

  // normal length
  logic [LEN_W-1:0] len_b;

  rsi_sqrt #(.RW(LEN_W)) u_sqrt_len (
    .clk  (clk),
    .rad  (lsq),
    .root (len_b)
  );

  // per-component division by the length
  logic [V_W-1:0] vm_b [3];
  logic [Q_W-1:0] q_c  [3];
  logic           vs_c [3];

  for (genvar i = 0; i < 3; i++) begin : g_norm
    rsi_delay #(.W(V_W), .N(ST_B - ST_A - 6)) u_dly_vm (
      .clk (clk),
      .d   (vm_a6[i]),
      .q   (vm_b[i])
    );
    rsi_delay #(.W(1), .N(ST_C - ST_A - 6)) u_dly_vs (
      .clk (clk),
      .d   (vs_a6[i]),
      .q   (vs_c[i])
    );
    rsi_div #(.NW(V_W), .DW(LEN_W), .QB(Q_W)) u_div (
      .clk (clk),
      .num (vm_b[i]),
      .den (len_b),
      .quo (q_c[i])
    );
  end

  // side data carried to the output stage
  logic                 lenz_c;
  logic                 miss_c;
  logic [RAD_W-1:0]     dist_c;
  logic signed [CW-1:0] hsat_c [3];

  rsi_delay #(.W(1), .N(DIV_LAT)) u_dly_lenz (
    .clk (clk),
    .d   (len_b == '0),
    .q   (lenz_c)
  );

  rsi_delay #(.W(1), .N(ST_C - ST_A - 2)) u_dly_miss (
    .clk (clk),
    .d   (miss_a2),
    .q   (miss_c)
  );

  rsi_delay #(.W(RAD_W), .N(ST_C - ST_A - 3)) u_dly_dist (
    .clk (clk),
    .d   (dist_a3),
    .q   (dist_c)
  );

  for (genvar i = 0; i < 3; i++) begin : g_dly_hit
    rsi_delay #(.W(CW), .N(ST_C - ST_A - 5)) u_dly_h (
      .clk (clk),
      .d   (hsat_a5[i]),
      .q   (hsat_c[i])
    );
  end

  // signed normal components, zero on miss or zero length
  logic signed [UW-1:0] nrm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (miss_c || lenz_c) begin
        nrm[i] = '0;
      end else if (vs_c[i]) begin
        nrm[i] = -$signed({1'b0, q_c[i]});
      end else begin
        nrm[i] = $signed({1'b0, q_c[i]});
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAT-1];
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    hit          <= !miss_c;
    hit_distance <= miss_c ? '0 : dist_c;
    hit_x        <= miss_c ? '0 : hsat_c[0];
    hit_y        <= miss_c ? '0 : hsat_c[1];
    hit_z        <= miss_c ? '0 : hsat_c[2];
    normal_x     <= nrm[0];
    normal_y     <= nrm[1];
    normal_z     <= nrm[2];
  end

  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result strobe missing after pipeline latency");

  // a miss reports all zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (hit_distance == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0
                        && normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("miss result carries nonzero fields");

  // normal components stay within unit range
  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_x <= NLIM && normal_x >= -NLIM && normal_y <= NLIM
              && normal_y >= -NLIM && normal_z <= NLIM && normal_z >= -NLIM))
    else $error("normal component out of unit range");

endmodule
